// File: hw/rtl/pds_pkg.sv
package pds_pkg;

  localparam int MAX_POINTS_DEF = 1024;
  localparam int COORD_W = 21;
  localparam int DIFF_W  = 22;
  localparam int SQ_W    = 60;  // (dx^2+dy^2)<<16 < 2^59
  localparam int ROOT_W  = 30;
  localparam int SUM_W   = 40;
  localparam int IDX_W   = 10;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_QUERY = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_OUT
  } state_t;

  // one stage of the square-root chain
  typedef struct packed {
    logic            vld;
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] root;
  } sqrt_stage_t;

endpackage

// File: hw/rtl/pds_if.sv
interface pds_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic signed [20:0] coord_x;
  logic signed [20:0] coord_y;
  logic [9:0]  query_index;
  modport source (output valid, func, coord_x, coord_y, query_index, input ready);
  modport sink   (input valid, func, coord_x, coord_y, query_index, output ready);
endinterface

interface pds_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  point_index;
  logic [39:0] distance_sum;
  logic        bad_index;
  modport source (output valid, point_index, distance_sum, bad_index, input ready);
  modport sink   (input valid, point_index, distance_sum, bad_index, output ready);
endinterface

// File: hw/rtl/pds_ram.sv
module pds_ram #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: hw/rtl/pds_sqrt_cell.sv
// One cell of the square-root chain: resolves one result bit per cycle and
// hands remainder and partial root to its neighbor.
module pds_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pds_pkg::sqrt_stage_t d_in,
  output pds_pkg::sqrt_stage_t d_out
);
  localparam logic [pds_pkg::SQ_W-1:0] BIT =
    pds_pkg::SQ_W'(1) << (pds_pkg::SQ_W - 2 - 2*STEP);

  pds_pkg::sqrt_stage_t d_r, d_nxt;
  logic [pds_pkg::SQ_W-1:0] trial;

  always_comb begin
    trial = d_in.root + BIT;
    d_nxt.vld = d_in.vld;
    if (d_in.rem >= trial) begin
      d_nxt.rem  = d_in.rem - trial;
      d_nxt.root = (d_in.root >> 1) + BIT;
    end else begin
      d_nxt.rem  = d_in.rem;
      d_nxt.root = d_in.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) d_r.vld <= 1'b0;
    else        d_r.vld <= d_nxt.vld;
    d_r.rem  <= d_nxt.rem;
    d_r.root <= d_nxt.root;
  end

  assign d_out = d_r;
endmodule

// File: hw/rtl/point_distance_sum_unit.sv
// Load and clear give no result; a bad-index query goes straight to the output.
// Query: the walk streams one stored point per cycle through the RAM read port
// into a 30-cell square-root chain.
// One item in flight at a time; results wait in an output register.
// rst_n (synchronous) empties the store; entries themselves are not cleared.
module point_distance_sum_unit #(
  parameter int MAX_POINTS = pds_pkg::MAX_POINTS_DEF
) (
  input logic     clk,
  input logic     rst_n,
  pds_in_if.sink   in_ch,
  pds_out_if.source out_ch
);
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int QW = (CW > pds_pkg::IDX_W) ? CW : pds_pkg::IDX_W;
  localparam int NC = pds_pkg::ROOT_W;
  localparam logic [pds_pkg::SUM_W-1:0] SUM_MAX = '1;

  pds_pkg::state_t st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] walk_r, walk_nxt;
  logic [pds_pkg::IDX_W-1:0] qi_r, qi_nxt;
  logic [pds_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic bad_r, bad_nxt;
  logic qload_r, qload_nxt;
  logic rd_vld_r;
  logic [5:0] drain_r, drain_nxt;
  logic signed [pds_pkg::COORD_W-1:0] qx_r, qy_r;

  logic we;
  logic [AW-1:0] raddr;
  logic [2*pds_pkg::COORD_W-1:0] rdata;
  logic in_fire;
  logic rd_req;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (st_r == pds_pkg::ST_IDLE);
  assign we = in_fire && (in_ch.func == pds_pkg::FUNC_LOAD) &&
              (cnt_r < CW'(MAX_POINTS));

  pds_ram #(.WIDTH(2*pds_pkg::COORD_W), .DEPTH(MAX_POINTS)) u_ram (
    .clk(clk), .we(we), .waddr(cnt_r[AW-1:0]),
    .wdata({in_ch.coord_x, in_ch.coord_y}),
    .raddr(raddr), .rdata(rdata)
  );

  // first read fetches the query point, then walk all entries
  assign raddr = qload_r ? AW'(qi_r) : walk_r[AW-1:0];
  assign rd_req = (st_r == pds_pkg::ST_WALK) && !qload_r && (walk_r < cnt_r);

  // difference and squares
  logic signed [pds_pkg::DIFF_W-1:0] dx, dy;
  logic [pds_pkg::DIFF_W-1:0] adx, ady;
  logic [2*pds_pkg::DIFF_W-1:0] sqx_r, sqy_r;
  logic sq_vld_r;
  logic [pds_pkg::SQ_W-1:0] rad;
  pds_pkg::sqrt_stage_t chain [NC+1];

  always_comb begin
    dx  = pds_pkg::DIFF_W'(qx_r) - pds_pkg::DIFF_W'($signed(rdata[41:21]));
    dy  = pds_pkg::DIFF_W'(qy_r) - pds_pkg::DIFF_W'($signed(rdata[20:0]));
    adx = dx[pds_pkg::DIFF_W-1] ? pds_pkg::DIFF_W'(-dx) : dx;
    ady = dy[pds_pkg::DIFF_W-1] ? pds_pkg::DIFF_W'(-dy) : dy;
    rad = pds_pkg::SQ_W'({sqx_r + sqy_r, 16'd0});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= 1'b0;
      rd_vld_r <= 1'b0;
    end else begin
      sq_vld_r <= rd_vld_r;
      rd_vld_r <= rd_req;
    end
    sqx_r <= adx * adx;
    sqy_r <= ady * ady;
  end

  assign chain[0].vld  = sq_vld_r;
  assign chain[0].rem  = rad;
  assign chain[0].root = '0;

  for (genvar g = 0; g < NC; g++) begin : g_cell
    pds_sqrt_cell #(.STEP(g)) u_cell (
      .clk(clk), .rst_n(rst_n), .d_in(chain[g]), .d_out(chain[g+1])
    );
  end

  logic [pds_pkg::SUM_W:0] acc;
  assign acc = {1'b0, sum_r} + (pds_pkg::SUM_W+1)'(chain[NC].root[pds_pkg::ROOT_W-1:0]);

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; walk_nxt = walk_r; qi_nxt = qi_r;
    sum_nxt = sum_r; bad_nxt = bad_r; qload_nxt = 1'b0; drain_nxt = drain_r;
    if (chain[NC].vld)
      sum_nxt = acc[pds_pkg::SUM_W] ? SUM_MAX : acc[pds_pkg::SUM_W-1:0];
    unique case (st_r)
      pds_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_ch.func)
            pds_pkg::FUNC_LOAD:  if (we) cnt_nxt = cnt_r + 1'b1;
            pds_pkg::FUNC_CLEAR: cnt_nxt = '0;
            pds_pkg::FUNC_QUERY: begin
              qi_nxt = in_ch.query_index;
              sum_nxt = '0;
              if (QW'(in_ch.query_index) >= QW'(cnt_r)) begin
                bad_nxt = 1'b1; st_nxt = pds_pkg::ST_OUT;
              end else begin
                bad_nxt = 1'b0; qload_nxt = 1'b1; walk_nxt = '0;
                st_nxt = pds_pkg::ST_WALK;
              end
            end
            default: ;
          endcase
        end
      end
      pds_pkg::ST_WALK: begin
        if (rd_req) walk_nxt = walk_r + 1'b1;
        if (!qload_r && !rd_req) begin
          drain_nxt = 6'(NC + 3); st_nxt = pds_pkg::ST_DRAIN;
        end
      end
      pds_pkg::ST_DRAIN: begin
        drain_nxt = drain_r - 1'b1;
        if (drain_r == '0) st_nxt = pds_pkg::ST_OUT;
      end
      pds_pkg::ST_OUT: if (out_ch.ready) st_nxt = pds_pkg::ST_IDLE;
      default: st_nxt = pds_pkg::ST_IDLE;
    endcase
  end

  // query point arrives in the cycle after its read
  logic qcap_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= pds_pkg::ST_IDLE; cnt_r <= '0; qload_r <= 1'b0; qcap_r <= 1'b0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; qload_r <= qload_nxt; qcap_r <= qload_r;
    end
    walk_r <= walk_nxt; qi_r <= qi_nxt; sum_r <= sum_nxt; bad_r <= bad_nxt;
    drain_r <= drain_nxt;
    if (qcap_r) begin
      qx_r <= $signed(rdata[41:21]);
      qy_r <= $signed(rdata[20:0]);
    end
  end

  assign out_ch.valid        = (st_r == pds_pkg::ST_OUT);
  assign out_ch.point_index  = qi_r;
  assign out_ch.distance_sum = bad_r ? '0 : sum_r;
  assign out_ch.bad_index    = bad_r;
endmodule

// File: hw/rtl/pds_checker.sv
module pds_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_bad_index,
  input logic [39:0] out_distance_sum
);
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_index |-> out_distance_sum == '0) else $error("bad sum");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("ready during result");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_distance_sum)) else $error("drop");
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("reset");
endmodule

bind point_distance_sum_unit pds_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_bad_index(out_ch.bad_index), .out_distance_sum(out_ch.distance_sum)
);

// File: sim/point_distance_sum_unit_tb.sv
`timescale 1ns / 1ps

module point_distance_sum_unit_tb;

  localparam int STORE_DEPTH = 1024;
  localparam longint unsigned SUM_SAT = (64'd1 << pds_pkg::SUM_W) - 64'd1;

  typedef struct {
    pds_pkg::func_t     func;
    logic signed [20:0] x;
    logic signed [20:0] y;
    logic [9:0]         qidx;
  } pds_cmd_t;

  typedef struct {
    logic [9:0]  point_index;
    logic [39:0] distance_sum;
    logic        bad_index;
  } pds_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pds_in_if  in_ch();
  pds_out_if out_ch();

  point_distance_sum_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  pds_cmd_t    cmd_queue[$];
  pds_result_t expected_sums[$];
  pds_cmd_t    cmd_cur;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          error_cnt = 0;

  // predictor copy of the point store
  int          store_x[STORE_DEPTH];
  int          store_y[STORE_DEPTH];
  int          store_cnt = 0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned rem, root, bitv;
    rem = v;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic longint unsigned distance_total(int idx);
    longint unsigned total, dx, dy;
    longint d;
    total = 0;
    for (int j = 0; j < store_cnt; j++) begin
      d = longint'(store_x[idx]) - longint'(store_x[j]);
      dx = (d < 0) ? -d : d;
      d = longint'(store_y[idx]) - longint'(store_y[j]);
      dy = (d < 0) ? -d : d;
      total = total + int_sqrt((dx * dx + dy * dy) << 16);
      if (total > SUM_SAT) total = SUM_SAT;
    end
    return total;
  endfunction

  function automatic void predict_cmd(pds_cmd_t c);
    pds_result_t r;
    case (c.func)
      pds_pkg::FUNC_LOAD: begin
        if (store_cnt < STORE_DEPTH) begin
          store_x[store_cnt] = c.x;
          store_y[store_cnt] = c.y;
          store_cnt++;
        end
      end
      pds_pkg::FUNC_CLEAR: store_cnt = 0;
      pds_pkg::FUNC_QUERY: begin
        r.point_index = c.qidx;
        if (int'(c.qidx) >= store_cnt) begin
          r.distance_sum = '0;
          r.bad_index = 1'b1;
        end else begin
          r.distance_sum = distance_total(c.qidx);
          r.bad_index = 1'b0;
        end
        expected_sums.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_cmd(cmd_cur);
      if (!in_ch.valid || in_ch.ready) begin
        if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd_cur = cmd_queue.pop_front();
          in_ch.func        <= cmd_cur.func;
          in_ch.coord_x     <= cmd_cur.x;
          in_ch.coord_y     <= cmd_cur.y;
          in_ch.query_index <= cmd_cur.qidx;
          in_ch.valid       <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    pds_result_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_sums.size() == 0) begin
          $display("%0t: unexpected result idx=%0d sum=%0d bad=%0b", $time,
                   out_ch.point_index, out_ch.distance_sum, out_ch.bad_index);
          error_cnt++;
        end else begin
          e = expected_sums.pop_front();
          if (out_ch.point_index !== e.point_index) begin
            $display("%0t: point_index exp %0d got %0d", $time, e.point_index,
                     out_ch.point_index);
            error_cnt++;
          end
          if (out_ch.distance_sum !== e.distance_sum) begin
            $display("%0t: distance_sum exp %0d got %0d", $time, e.distance_sum,
                     out_ch.distance_sum);
            error_cnt++;
          end
          if (out_ch.bad_index !== e.bad_index) begin
            $display("%0t: bad_index exp %0b got %0b", $time, e.bad_index,
                     out_ch.bad_index);
            error_cnt++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic void add_cmd(pds_pkg::func_t f, int x, int y, int q);
    pds_cmd_t c;
    c.func = f;
    c.x = x;
    c.y = y;
    c.qidx = q;
    cmd_queue.push_back(c);
  endfunction

  function automatic int rand_coord();
    case ($urandom_range(9))
      0: return $urandom_range(2097151) - 1048576;  // full 21-bit range
      1: return ($urandom_range(1)) ? 1000000 : -1000000;
      2: return $urandom_range(20) - 10;
      default: return $urandom_range(2000000) - 1000000;
    endcase
  endfunction

  // random transactions: mostly clear/load/query sequences, some noise
  task automatic gen_random(int n_items);
    int made, npts;
    made = 0;
    while (made < n_items) begin
      if ($urandom_range(9) == 0) begin
        add_cmd(pds_pkg::func_t'($urandom_range(3)), $urandom_range(2097151) - 1048576,
                $urandom_range(2097151) - 1048576, $urandom_range(1023));
        made++;
      end else begin
        if ($urandom_range(3) != 0) begin
          add_cmd(pds_pkg::FUNC_CLEAR, rand_coord(), rand_coord(), $urandom_range(1023));
          made++;
        end
        npts = ($urandom_range(7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
        for (int i = 0; i < npts; i++) begin
          add_cmd(pds_pkg::FUNC_LOAD, rand_coord(), rand_coord(), $urandom_range(1023));
          made++;
        end
        for (int i = $urandom_range(1, 4); i > 0; i--) begin
          if ($urandom_range(5) == 0)
            add_cmd(pds_pkg::FUNC_QUERY, rand_coord(), rand_coord(), $urandom_range(1023));
          else
            add_cmd(pds_pkg::FUNC_QUERY, rand_coord(), rand_coord(),
                    $urandom_range(npts - 1));
          made++;
        end
      end
    end
  endtask

  // sender holds off until every transaction is in and every result is back
  task automatic drain();
    wait (cmd_queue.size() == 0 && !in_ch.valid);
    wait (expected_sums.size() == 0);
    repeat (50) @(posedge clk);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = pds_pkg::FUNC_NONE;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
    in_ch.query_index = '0;
    out_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    add_cmd(pds_pkg::FUNC_QUERY, 0, 0, 0);
    add_cmd(pds_pkg::FUNC_LOAD, 1000000, 1000000, 0);
    add_cmd(pds_pkg::FUNC_LOAD, -1000000, -1000000, 0);
    add_cmd(pds_pkg::FUNC_LOAD, 1048575, -1048576, 1023);
    add_cmd(pds_pkg::FUNC_LOAD, -1048576, 1048575, 0);
    add_cmd(pds_pkg::FUNC_LOAD, 0, 0, 0);
    add_cmd(pds_pkg::FUNC_NONE, 5, 5, 0);
    for (int i = 0; i < 5; i++) add_cmd(pds_pkg::FUNC_QUERY, 0, 0, i);
    add_cmd(pds_pkg::FUNC_QUERY, 0, 0, 5);
    add_cmd(pds_pkg::FUNC_QUERY, 0, 0, 1023);
    add_cmd(pds_pkg::FUNC_CLEAR, 0, 0, 0);
    add_cmd(pds_pkg::FUNC_QUERY, 0, 0, 0);
    add_cmd(pds_pkg::FUNC_LOAD, -7, 3, 0);
    add_cmd(pds_pkg::FUNC_QUERY, 0, 0, 0);
    drain();

    send_idle_pct = 21;
    recv_idle_pct = 77;
    gen_random(185);
    drain();

    send_idle_pct = 77;
    recv_idle_pct = 21;
    gen_random(185);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    gen_random(180);
    drain();

    if (error_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/pds_pkg.sv
hw/rtl/pds_if.sv
hw/rtl/pds_ram.sv
hw/rtl/pds_sqrt_cell.sv
hw/rtl/point_distance_sum_unit.sv
hw/rtl/pds_checker.sv
sim/point_distance_sum_unit_tb.sv
